>>> rtl/spdg_pkg.sv
// Shared types, constants and codes for the dense-graph shortest path block.
// No dependencies; imported by every module of the block.
package spdg_pkg;

  // Default sizing handed to the top-level parameters
  localparam int DEF_MAX_NODES   = 32;
  localparam int DEF_WEIGHT_BITS = 16;

  // Fixed field widths
  localparam int DIST_W   = 22;
  localparam int NODE_W   = 6;
  localparam int CFG_W    = 6;
  localparam int ROW_W    = 5;
  localparam int WIN_W    = 16;
  localparam int CMP_W    = 8;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

  // Input commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_NODE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_END_NODE   = 2'd2;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] RST_NODE_COUNT = 6'd32;
  localparam logic [CFG_W-1:0] RST_START_NODE = 6'd1;
  localparam logic [CFG_W-1:0] RST_END_NODE   = 6'd1;

  typedef struct packed {
    logic [CFG_W-1:0] node_count;
    logic [CFG_W-1:0] start_node;
    logic [CFG_W-1:0] end_node;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_RELAX,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_FAIL
  } state_t;

endpackage

>>> rtl/spdg_regs.sv
// APB-style configuration registers: node count, start node, end node.
// Depends on spdg_pkg.
module spdg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spdg_pkg::APB_AW-1:0] paddr,
  input  logic [spdg_pkg::APB_DW-1:0] pwdata,
  output logic [spdg_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output spdg_pkg::cfg_t              cfg
);
  import spdg_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write on the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_count <= RST_NODE_COUNT;
      cfg_r.start_node <= RST_START_NODE;
      cfg_r.end_node   <= RST_END_NODE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NODE_COUNT: cfg_r.node_count <= pwdata[CFG_W-1:0];
        REG_START_NODE: cfg_r.start_node <= pwdata[CFG_W-1:0];
        REG_END_NODE:   cfg_r.end_node   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_NODE_COUNT: prdata = APB_DW'(cfg_r.node_count);
      REG_START_NODE: prdata = APB_DW'(cfg_r.start_node);
      REG_END_NODE:   prdata = APB_DW'(cfg_r.end_node);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> rtl/shortest_path_dense_graph.sv
// Top level of the dense-graph shortest path search (Dijkstra over a weight matrix).
// Depends on spdg_pkg and spdg_regs.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | command, row, col, weight
//   out_    | output    | out_valid/out_ready | node, last, unreachable
//   cfg     | input     | psel/penable/pready | paddr, pwdata, prdata
//
// A weight load is written from the input while idle. A search sets up the
// node state, then per closed node scans for the closest open node and
// relaxes its row over the node-state memory, then walks the path back
// node by node from the end node and emits it from the start node.
// Reset is synchronous; no memory needs clearing after it. A stalled result
// holds the block in its emit state; weight loads wait only while a search runs.
module shortest_path_dense_graph #(
  parameter int MAX_NODES   = spdg_pkg::DEF_MAX_NODES,
  parameter int WEIGHT_BITS = spdg_pkg::DEF_WEIGHT_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [spdg_pkg::ROW_W-1:0]  in_row,
  input  logic [spdg_pkg::ROW_W-1:0]  in_col,
  input  logic [spdg_pkg::WIN_W-1:0]  in_weight,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [spdg_pkg::NODE_W-1:0] out_node,
  output logic                        out_last,
  output logic                        out_unreachable,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spdg_pkg::APB_AW-1:0] paddr,
  input  logic [spdg_pkg::APB_DW-1:0] pwdata,
  output logic [spdg_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import spdg_pkg::*;

  localparam int NW    = $clog2(MAX_NODES);
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int WA_W  = $clog2(MAX_NODES * MAX_NODES);
  localparam int ENT_W = 1 + NW + DIST_W;
  localparam int SUM_W = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;
  localparam logic [WEIGHT_BITS-1:0] WMASK = {WEIGHT_BITS{1'b1}};

  cfg_t cfg;

  spdg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Memories: weight matrix, node state {closed, parent, distance}, path buffer
  logic [WEIGHT_BITS-1:0] wmem [MAX_NODES*MAX_NODES];
  logic [ENT_W-1:0]       nmem [MAX_NODES];
  logic [NW-1:0]          pmem [MAX_NODES];

  logic                   wm_we;
  logic [WA_W-1:0]        wm_waddr, wm_raddr;
  logic [WEIGHT_BITS-1:0] wm_wdata, wm_rd;
  logic                   nm_we;
  logic [NW-1:0]          nm_waddr, nm_raddr;
  logic [ENT_W-1:0]       nm_wdata, nm_rd;
  logic                   pm_we;
  logic [NW-1:0]          pm_waddr, pm_raddr;
  logic [NW-1:0]          pm_wdata, pm_rd;

  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[wm_waddr] <= wm_wdata;
    end
    wm_rd <= wmem[wm_raddr];
  end

  always_ff @(posedge clk) begin
    if (nm_we) begin
      nmem[nm_waddr] <= nm_wdata;
    end
    nm_rd <= nmem[nm_raddr];
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_waddr] <= pm_wdata;
    end
    pm_rd <= pmem[pm_raddr];
  end

  // Control and datapath registers
  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [NW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [DIST_W-1:0]   best_dist_r, best_dist_nxt;
  logic [NW-1:0]       best_idx_r, best_idx_nxt;
  logic                found_r, found_nxt;
  logic [NW-1:0]       e_r, e_nxt;
  logic [CW-1:0]       len_r, len_nxt;
  logic [NW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [NW-1:0]       src_r, src_nxt;
  logic [NW-1:0]       dst_r, dst_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]   out_node_r, out_node_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_unr_r, out_unr_nxt;

  // Fields of the node-state read data and derived values
  logic                rd_closed;
  logic [NW-1:0]       rd_par;
  logic [DIST_W-1:0]   rd_dist;
  logic [SUM_W-1:0]    sum;
  logic [DIST_W-1:0]   sum_sat;
  logic [CW-1:0]       n_clamp;
  logic [CFG_W-1:0]    start_m1, end_m1;
  logic                range_bad;
  logic                out_free;

  assign rd_closed = nm_rd[ENT_W-1];
  assign rd_par    = nm_rd[DIST_W+NW-1:DIST_W];
  assign rd_dist   = nm_rd[DIST_W-1:0];
  assign sum       = SUM_W'(best_dist_r) + SUM_W'(wm_rd);
  assign sum_sat   = (sum > SUM_W'(DIST_INF)) ? DIST_INF : sum[DIST_W-1:0];
  assign start_m1  = cfg.start_node - CFG_W'(1);
  assign end_m1    = cfg.end_node - CFG_W'(1);
  assign out_free  = !out_valid_r || out_ready;

  // Clamp node count to 1..MAX_NODES
  always_comb begin
    if (cfg.node_count == '0) begin
      n_clamp = CW'(1);
    end else if (CMP_W'(cfg.node_count) > CMP_W'(MAX_NODES)) begin
      n_clamp = CW'(MAX_NODES);
    end else begin
      n_clamp = CW'(cfg.node_count);
    end
  end

  assign range_bad = (cfg.start_node == '0) || (cfg.end_node == '0) ||
                     (CMP_W'(cfg.start_node) > CMP_W'(n_clamp)) ||
                     (CMP_W'(cfg.end_node) > CMP_W'(n_clamp));

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_node        = out_node_r;
  assign out_last        = out_last_r;
  assign out_unreachable = out_unr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    found_r     <= found_nxt;
    e_r         <= e_nxt;
    len_r       <= len_nxt;
    idx_r       <= idx_nxt;
    n_r         <= n_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    out_node_r  <= out_node_nxt;
    out_last_r  <= out_last_nxt;
    out_unr_r   <= out_unr_nxt;
  end

  // Sequencer: load weights, or set up, scan for the closest open node, relax its row, walk back, emit or fail
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    found_nxt     = found_r;
    e_nxt         = e_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_node_nxt  = out_node_r;
    out_last_nxt  = out_last_r;
    out_unr_nxt   = out_unr_r;

    wm_we    = 1'b0;
    wm_waddr = WA_W'(in_row) * WA_W'(MAX_NODES) + WA_W'(in_col);
    wm_wdata = WEIGHT_BITS'(in_weight);
    wm_raddr = WA_W'(best_idx_r) * WA_W'(MAX_NODES) + WA_W'(cnt_r[NW-1:0]);
    nm_we    = 1'b0;
    nm_waddr = rd_idx_r;
    nm_wdata = nm_rd;
    nm_raddr = (state_r == ST_WALK_RD) ? e_r : cnt_r[NW-1:0];
    pm_we    = 1'b0;
    pm_waddr = len_r[NW-1:0];
    pm_wdata = e_r;
    pm_raddr = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_LOAD) begin
            // Drop writes outside the matrix
            wm_we = (CMP_W'(in_row) < CMP_W'(MAX_NODES)) &&
                    (CMP_W'(in_col) < CMP_W'(MAX_NODES));
          end else begin
            n_nxt   = n_clamp;
            src_nxt = NW'(start_m1);
            dst_nxt = NW'(end_m1);
            cnt_nxt = '0;
            state_nxt = range_bad ? ST_FAIL : ST_INIT;
          end
        end
      end

      ST_INIT: begin
        nm_we    = 1'b1;
        nm_waddr = cnt_r[NW-1:0];
        nm_wdata = {1'b0, {NW{1'b0}}, (cnt_r[NW-1:0] == src_r) ? {DIST_W{1'b0}} : DIST_INF};
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_r + CW'(1) == n_r) begin
          cnt_nxt       = '0;
          best_dist_nxt = DIST_INF;
          best_idx_nxt  = '0;
          found_nxt     = 1'b0;
          state_nxt     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (cnt_r < n_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[NW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
        end
        // Keep the first open node with the least distance
        if (rd_vld_r && !rd_closed && (rd_dist < best_dist_r)) begin
          best_dist_nxt = rd_dist;
          best_idx_nxt  = rd_idx_r;
          found_nxt     = 1'b1;
        end
        if ((cnt_r == n_r) && !rd_vld_r) begin
          cnt_nxt = '0;
          if (found_r) begin
            state_nxt = ST_RELAX;
          end else begin
            e_nxt     = dst_r;
            len_nxt   = '0;
            state_nxt = ST_WALK_RD;
          end
        end
      end

      ST_RELAX: begin
        if (cnt_r < n_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[NW-1:0];
          cnt_nxt    = cnt_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (rd_idx_r == best_idx_r) begin
            // Close the selected node
            nm_we    = 1'b1;
            nm_wdata = {1'b1, rd_par, rd_dist};
          end else if (!rd_closed && (wm_rd != WMASK) && (sum_sat < rd_dist)) begin
            nm_we    = 1'b1;
            nm_wdata = {1'b0, best_idx_r, sum_sat};
          end
        end
        if ((cnt_r == n_r) && !rd_vld_r) begin
          cnt_nxt       = '0;
          best_dist_nxt = DIST_INF;
          best_idx_nxt  = '0;
          found_nxt     = 1'b0;
          state_nxt     = ST_SCAN;
        end
      end

      ST_WALK_RD: begin
        state_nxt = ST_WALK_CHK;
      end

      ST_WALK_CHK: begin
        if ((len_r == '0) && (rd_dist == DIST_INF)) begin
          state_nxt = ST_FAIL;
        end else begin
          pm_we   = 1'b1;
          len_nxt = len_r + CW'(1);
          if (e_r == src_r) begin
            idx_nxt   = len_r[NW-1:0];
            state_nxt = ST_EMIT_RD;
          end else if (len_r + CW'(1) >= n_r) begin
            state_nxt = ST_FAIL;
          end else begin
            e_nxt     = rd_par;
            state_nxt = ST_WALK_RD;
          end
        end
      end

      ST_EMIT_RD: begin
        if (out_free) begin
          state_nxt = ST_EMIT_LD;
        end
      end

      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_node_nxt  = NODE_W'(pm_rd) + NODE_W'(1);
        out_last_nxt  = (idx_r == '0);
        out_unr_nxt   = 1'b0;
        if (idx_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r - NW'(1);
          state_nxt = ST_EMIT_RD;
        end
      end

      ST_FAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_unr_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/spdg_checker.sv
// Port-level checks for the shortest path block, bound to its top level.
// Depends on spdg_pkg and shortest_path_dense_graph.
module spdg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_command,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [spdg_pkg::NODE_W-1:0] out_node,
  input logic                        out_last,
  input logic                        out_unreachable,
  input logic                        pready
);
  import spdg_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node))
    else $error("result dropped or changed while stalled");

  // An unreachable result is a lone node-zero final transaction
  a_unr_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unreachable |-> out_last && (out_node == '0))
    else $error("malformed unreachable result");

  // A search makes the block busy
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_SEARCH) |=> !in_ready)
    else $error("input accepted during search");

  // A weight load does not stall the input
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_LOAD) |=> in_ready)
    else $error("weight load stalled the input");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind shortest_path_dense_graph spdg_checker u_spdg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_command      (in_command),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_node        (out_node),
  .out_last        (out_last),
  .out_unreachable (out_unreachable),
  .pready          (pready)
);
